// ===== design/spq_pkg.sv =====
// Shared types and constants for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int TAG_W       = 16;
    localparam int AGE_W       = 7;
    localparam int PRIO_W      = 4;
    localparam int ENTRY_W     = TAG_W + AGE_W + PRIO_W;
    localparam int COUNT_OUT_W = 5;

    localparam logic [AGE_W-1:0] AGE_START_MIN = 7'd100;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [AGE_W-1:0]  age;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

endpackage

// ===== design/stable_priority_queue_with_age_stats.sv =====
// Top level of the stable priority queue with age statistics.
//
// Usage: each input word carries a command (enqueue or dequeue) with a tag,
// age and priority. Entries leave in ascending priority number; equal
// priorities leave in arrival order. Every input word yields exactly one
// output word: a status, the removed entry (zero unless dequeued), the entry
// count and the largest and smallest stored ages (smallest starts at 100).
// Both channels use valid/ready; a word moves when both are high.
// Entries sit in a single RAM with registered read data, kept in service
// order with slot 0 at the front; a sequencer walks it one slot a cycle.
// An enqueue reads from the back and moves each entry of larger priority
// number one slot back before it writes the new entry; a dequeue reads the
// head, then moves every later entry one slot forward and folds its age into
// the extremes; a refused or ignored word goes straight to the finish state.
// The next word is taken once the result has loaded and the sequencer is
// idle again; a full queue of 16 has the longest walk.
// The input is taken only while the sequencer is idle; a finished result
// waits in the output register, and if the receiver stalls while a second
// result is ready, the sequencer holds that result until the register frees.
// Reset empties the queue at once (count to zero); the RAM is not cleared,
// since only slots below the count are ever read.
`timescale 1ns / 1ps

module stable_priority_queue_with_age_stats #(
    parameter int CAPACITY = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        command,
    input  logic [spq_pkg::TAG_W-1:0]   entry_tag,
    input  logic [spq_pkg::AGE_W-1:0]   entry_age,
    input  logic [spq_pkg::PRIO_W-1:0]  entry_priority,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  op_status,
    output logic [spq_pkg::TAG_W-1:0]   out_tag,
    output logic [spq_pkg::AGE_W-1:0]   out_age,
    output logic [spq_pkg::PRIO_W-1:0]  out_priority,
    output logic [spq_pkg::COUNT_OUT_W-1:0] entry_count,
    output logic [spq_pkg::AGE_W-1:0]   oldest_age,
    output logic [spq_pkg::AGE_W-1:0]   youngest_age
);
    import spq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_COUNT = CW'(1);

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_ENQ_WALK  = 7'b0000010,
        S_PUT       = 7'b0000100,
        S_DEQ_HEAD  = 7'b0001000,
        S_DEQ_WALK  = 7'b0010000,
        S_FINISH    = 7'b0100000,
        S_SPARE     = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [AW-1:0]   put_addr_reg, put_addr_next;
    entry_t          new_reg, new_next;
    entry_t          removed_reg, removed_next;
    status_t         status_reg, status_next;
    // age extremes of the stored entries; also the accumulators of a dequeue walk
    logic [AGE_W-1:0] oldest_reg, oldest_next;
    logic [AGE_W-1:0] youngest_reg, youngest_next;

    // output register
    logic            out_valid_reg, out_valid_next;
    status_t         o_status_reg, o_status_next;
    entry_t          o_entry_reg, o_entry_next;
    logic [CW-1:0]   o_count_reg, o_count_next;
    logic [AGE_W-1:0] o_oldest_reg, o_oldest_next;
    logic [AGE_W-1:0] o_youngest_reg, o_youngest_next;

    // RAM port
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    entry_t          rd_data;

    logic [CW-1:0]   count_less_one;
    logic [CW-1:0]   ptr_wide;
    logic [CW+COUNT_OUT_W-1:0] count_out_wide;
    logic            accept;

    spq_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign accept         = in_valid && in_ready;
    assign count_less_one = count_reg - ONE_COUNT;
    assign ptr_wide       = CW'(ptr_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        put_addr_next   = put_addr_reg;
        new_next        = new_reg;
        removed_next    = removed_reg;
        status_next     = status_reg;
        oldest_next     = oldest_reg;
        youngest_next   = youngest_reg;
        out_valid_next  = out_valid_reg;
        o_status_next   = o_status_reg;
        o_entry_next    = o_entry_reg;
        o_count_next    = o_count_reg;
        o_oldest_next   = o_oldest_reg;
        o_youngest_next = o_youngest_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = '0;

        // drop the output word once the receiver takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    new_next     = '{tag: entry_tag, age: entry_age, prio: entry_priority};
                    removed_next = '0;
                    if (command == CMD_ENQUEUE)
                    begin
                        if (count_reg >= CAP_COUNT)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else if (count_reg == '0)
                        begin
                            put_addr_next = '0;
                            state_next    = S_PUT;
                        end
                        else
                        begin
                            // start at the back and walk towards the front
                            rd_en      = 1'b1;
                            rd_addr    = count_less_one[AW-1:0];
                            ptr_next   = count_less_one[AW-1:0];
                            state_next = S_ENQ_WALK;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            ptr_next   = '0;
                            state_next = S_DEQ_HEAD;
                        end
                    end
                end
            end

            S_ENQ_WALK:
            begin
                if (rd_data.prio > new_reg.prio)
                begin
                    // shift this entry one slot back
                    wr_en   = 1'b1;
                    wr_addr = ptr_reg + AW'(1);
                    wr_data = rd_data;
                    if (ptr_reg == '0)
                    begin
                        put_addr_next = '0;
                        state_next    = S_PUT;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ptr_reg - AW'(1);
                        ptr_next = ptr_reg - AW'(1);
                    end
                end
                else
                begin
                    put_addr_next = ptr_reg + AW'(1);
                    state_next    = S_PUT;
                end
            end

            S_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = put_addr_reg;
                wr_data     = new_reg;
                count_next  = count_reg + ONE_COUNT;
                status_next = ST_ENQUEUED;
                if (new_reg.age > oldest_reg)
                begin
                    oldest_next = new_reg.age;
                end
                if (new_reg.age < youngest_reg)
                begin
                    youngest_next = new_reg.age;
                end
                state_next = S_FINISH;
            end

            S_DEQ_HEAD:
            begin
                removed_next  = rd_data;
                status_next   = ST_DEQUEUED;
                oldest_next   = '0;
                youngest_next = AGE_START_MIN;
                if (count_reg == ONE_COUNT)
                begin
                    count_next = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(1);
                    ptr_next   = AW'(1);
                    state_next = S_DEQ_WALK;
                end
            end

            S_DEQ_WALK:
            begin
                // move forward one slot and fold its age into the extremes
                wr_en   = 1'b1;
                wr_addr = ptr_reg - AW'(1);
                wr_data = rd_data;
                if (rd_data.age > oldest_reg)
                begin
                    oldest_next = rd_data.age;
                end
                if (rd_data.age < youngest_reg)
                begin
                    youngest_next = rd_data.age;
                end
                if (ptr_wide == count_less_one)
                begin
                    count_next = count_less_one;
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + AW'(1);
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    o_status_next   = status_reg;
                    o_entry_next    = removed_reg;
                    o_count_next    = count_reg;
                    o_oldest_next   = oldest_reg;
                    o_youngest_next = youngest_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            oldest_reg    <= '0;
            youngest_reg  <= AGE_START_MIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            youngest_reg  <= youngest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        put_addr_reg   <= put_addr_next;
        new_reg        <= new_next;
        removed_reg    <= removed_next;
        status_reg     <= status_next;
        o_status_reg   <= o_status_next;
        o_entry_reg    <= o_entry_next;
        o_count_reg    <= o_count_next;
        o_oldest_reg   <= o_oldest_next;
        o_youngest_reg <= o_youngest_next;
    end

    // the count leaves masked to the port width
    assign count_out_wide = {{COUNT_OUT_W{1'b0}}, o_count_reg};

    assign out_valid    = out_valid_reg;
    assign op_status    = o_status_reg;
    assign out_tag      = o_entry_reg.tag;
    assign out_age      = o_entry_reg.age;
    assign out_priority = o_entry_reg.prio;
    assign entry_count  = count_out_wide[COUNT_OUT_W-1:0];
    assign oldest_age   = o_oldest_reg;
    assign youngest_age = o_youngest_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("entry count exceeds capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("sequencer idle right after accepting a word");

    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (op_status != ST_DEQUEUED) |->
            (out_tag == '0) && (out_age == '0) && (out_priority == '0))
        else $error("removed entry fields set without a dequeue");

    a_youngest_cap: assert property (@(posedge clk) disable iff (!rst_n)
        youngest_reg <= AGE_START_MIN)
        else $error("youngest age above start value");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg != S_IDLE)
        else $error("RAM written while idle");

endmodule

// ===== design/spq_ram.sv =====
// Single-port-write, single-port-read entry store with registered read data.
`timescale 1ns / 1ps

module spq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  spq_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output spq_pkg::entry_t rd_data
);
    import spq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the stable priority queue with age statistics.
`timescale 1ns / 1ps

module testbench;

    import spq_pkg::*;

    // Queue depth under test; the predictor mirrors the same bound.
    localparam int DEPTH = 16;
    // Give up after this many cycles in which no word moves on either channel.
    localparam int STALL_LIMIT = 3000;
    // Cycles to hold after the last result, enough for a full walk of the RAM.
    localparam int DRAIN_CYCLES = 40;
    localparam int WORDS_PER_PHASE = 250;

    // One input word as the sender presents it.
    typedef struct packed {
        logic   command;
        entry_t entry;
    } in_word_t;

    // One output word, field for field as the block reports it.
    typedef struct packed {
        status_t                status;
        entry_t                 removed;
        logic [COUNT_OUT_W-1:0] count;
        logic [AGE_W-1:0]       oldest;
        logic [AGE_W-1:0]       youngest;
    } out_word_t;

    // A row of the directed table: the word, and where it is obvious, its result.
    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t want;
    } table_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   command = CMD_ENQUEUE;
    logic [TAG_W-1:0]       entry_tag = '0;
    logic [AGE_W-1:0]       entry_age = '0;
    logic [PRIO_W-1:0]      entry_priority = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [1:0]             op_status;
    logic [TAG_W-1:0]       out_tag;
    logic [AGE_W-1:0]       out_age;
    logic [PRIO_W-1:0]      out_priority;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [AGE_W-1:0]       oldest_age;
    logic [AGE_W-1:0]       youngest_age;

    // Predictor state: slots in service order, slot 0 at the front.
    entry_t     shadow_slots[DEPTH];
    int         shadow_held = 0;

    out_word_t  awaited_results[$];
    table_row_t directed_rows[$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    always #4 clk = ~clk;

    stable_priority_queue_with_age_stats #(
        .CAPACITY(DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .entry_tag      (entry_tag),
        .entry_age      (entry_age),
        .entry_priority (entry_priority),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .op_status      (op_status),
        .out_tag        (out_tag),
        .out_age        (out_age),
        .out_priority   (out_priority),
        .entry_count    (entry_count),
        .oldest_age     (oldest_age),
        .youngest_age   (youngest_age)
    );

    // Apply one accepted word to the shadow queue and return the result it must
    // produce. An enqueue goes behind every entry of smaller or equal priority
    // number, which keeps equal priorities in arrival order.
    function automatic out_word_t apply_to_shadow(input in_word_t w);
        out_word_t        r;
        int               pos;
        logic [AGE_W-1:0] hi;
        logic [AGE_W-1:0] lo;
        r = '0;
        if (w.command == CMD_ENQUEUE) begin
            if (shadow_held >= DEPTH) begin
                // Full: drop the entry, leave the queue alone.
                r.status = ST_FULL;
            end
            else begin
                pos = 0;
                while (pos < shadow_held && shadow_slots[pos].prio <= w.entry.prio)
                    pos++;
                for (int i = shadow_held; i > pos; i--)
                    shadow_slots[i] = shadow_slots[i-1];
                shadow_slots[pos] = w.entry;
                shadow_held++;
                r.status = ST_ENQUEUED;
            end
        end
        else begin
            if (shadow_held == 0) begin
                // Empty: ignore the dequeue, removed fields stay zero.
                r.status = ST_EMPTY;
            end
            else begin
                r.removed = shadow_slots[0];
                for (int i = 1; i < shadow_held; i++)
                    shadow_slots[i-1] = shadow_slots[i];
                shadow_held--;
                r.status = ST_DEQUEUED;
            end
        end
        // Recompute the age extremes; the minimum starts from its ceiling of 100.
        hi = '0;
        lo = AGE_START_MIN;
        for (int i = 0; i < shadow_held; i++) begin
            if (shadow_slots[i].age > hi)
                hi = shadow_slots[i].age;
            if (shadow_slots[i].age < lo)
                lo = shadow_slots[i].age;
        end
        r.count    = shadow_held[COUNT_OUT_W-1:0];
        r.oldest   = hi;
        r.youngest = lo;
        return r;
    endfunction

    function automatic in_word_t make_word(input logic cmd, input logic [TAG_W-1:0] tag,
                                           input logic [AGE_W-1:0] age,
                                           input logic [PRIO_W-1:0] prio);
        in_word_t w;
        w.command    = cmd;
        w.entry.tag  = tag;
        w.entry.age  = age;
        w.entry.prio = prio;
        return w;
    endfunction

    function automatic void add_row(input in_word_t w, input bit typed, input out_word_t want);
        table_row_t row;
        row.word  = w;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Random word with a given share of enqueues. Ages lean towards both ends so
    // that the extremes, and the clamp of the minimum at 100, are hit often;
    // priorities lean towards a narrow band so that ties are common.
    function automatic in_word_t random_word(input int enq_pct);
        in_word_t w;
        w.command   = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
        w.entry.tag = TAG_W'($urandom);
        case ($urandom_range(3))
            0:       w.entry.age = AGE_W'($urandom_range(127, 100));
            1:       w.entry.age = AGE_W'($urandom_range(5, 0));
            default: w.entry.age = AGE_W'($urandom_range(127, 0));
        endcase
        w.entry.prio = $urandom_range(1) ? PRIO_W'($urandom_range(15, 0))
                                         : PRIO_W'($urandom_range(6, 5));
        return w;
    endfunction

    task automatic check_field(input string label, input logic [TAG_W-1:0] want,
                               input logic [TAG_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    // Present one word and hold it until it is taken, then queue its result.
    // A typed expectation replaces the predicted one, but the shadow queue
    // advances either way.
    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        out_word_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= w.command;
        entry_tag      <= w.entry.tag;
        entry_age      <= w.entry.age;
        entry_priority <= w.entry.prio;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_to_shadow(w);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid and hold until every result owed has come back.
    task automatic wait_for_results;
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side: check each word taken against the oldest expectation, then
    // draw the ready for the next cycle.
    always @(posedge clk) begin : result_monitor
        out_word_t want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, actual status %0d",
                         $time, op_status);
            end
            else begin
                want = awaited_results.pop_front();
                check_field("op_status", TAG_W'(want.status), TAG_W'(op_status));
                check_field("out_tag", want.removed.tag, out_tag);
                check_field("out_age", TAG_W'(want.removed.age), TAG_W'(out_age));
                check_field("out_priority", TAG_W'(want.removed.prio),
                            TAG_W'(out_priority));
                check_field("entry_count", TAG_W'(want.count), TAG_W'(entry_count));
                check_field("oldest_age", TAG_W'(want.oldest), TAG_W'(oldest_age));
                check_field("youngest_age", TAG_W'(want.youngest), TAG_W'(youngest_age));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: count cycles in which no word moves on either side.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int enq_mix[5];
        enq_mix = '{85, 15, 60, 80, 25};

        // Directed table. Results are typed in only where they follow at once
        // from the rules: the empty queue, the extreme fields and the full flag.
        add_row(make_word(CMD_DEQUEUE, 16'h0000, 7'd0, 4'd0), 1'b1,
                '{status: ST_EMPTY, removed: '0, count: 5'd0, oldest: 7'd0,
                  youngest: 7'd100});
        add_row(make_word(CMD_ENQUEUE, 16'hFFFF, 7'd127, 4'd15), 1'b1,
                '{status: ST_ENQUEUED, removed: '0, count: 5'd1, oldest: 7'd127,
                  youngest: 7'd100});
        add_row(make_word(CMD_ENQUEUE, 16'h0000, 7'd0, 4'd0), 1'b1,
                '{status: ST_ENQUEUED, removed: '0, count: 5'd2, oldest: 7'd127,
                  youngest: 7'd0});
        add_row(make_word(CMD_DEQUEUE, 16'h0000, 7'd0, 4'd0), 1'b1,
                '{status: ST_DEQUEUED, removed: '{tag: 16'h0000, age: 7'd0, prio: 4'd0},
                  count: 5'd1, oldest: 7'd127, youngest: 7'd100});
        add_row(make_word(CMD_DEQUEUE, 16'h0000, 7'd0, 4'd0), 1'b1,
                '{status: ST_DEQUEUED, removed: '{tag: 16'hFFFF, age: 7'd127, prio: 4'd15},
                  count: 5'd0, oldest: 7'd0, youngest: 7'd100});
        // Fill to capacity with two interleaved priorities, so ties must keep
        // arrival order and later low numbers must jump ahead.
        for (int i = 0; i < DEPTH; i++)
            add_row(make_word(CMD_ENQUEUE, 16'h1000 + i[15:0], 7'd50,
                              (i % 2) ? 4'd3 : 4'd7), 1'b0, '0);
        add_row(make_word(CMD_ENQUEUE, 16'hA5A5, 7'd1, 4'd0), 1'b1,
                '{status: ST_FULL, removed: '0, count: 5'd16, oldest: 7'd50,
                  youngest: 7'd50});
        add_row(make_word(CMD_DEQUEUE, 16'h0000, 7'd0, 4'd0), 1'b0, '0);
        add_row(make_word(CMD_DEQUEUE, 16'h0000, 7'd0, 4'd0), 1'b0, '0);
        add_row(make_word(CMD_ENQUEUE, 16'h5A5A, 7'd100, 4'd3), 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: sender idles lightly, receiver heavily.
        send_idle_pct = 20;
        recv_idle_pct = 58;
        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 20; recv_idle_pct = 58; end
                1: begin send_idle_pct = 58; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            // Swing the enqueue share every 25 words so the queue runs from
            // empty to full and back.
            for (int k = 0; k < WORDS_PER_PHASE; k++)
                send_word(random_word(enq_mix[(k / 25) % 5]), 1'b0, '0);
            // Hold the sender until the block has drained every result owed.
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end
        else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
